// ----- sv/g2b_pkg.sv -----
// Shared constants and types for the Gaussian integer to base (i-1) converter.
package g2b_pkg;

  localparam int IN_WIDTH    = 16;
  localparam int MAX_DIGITS  = 64;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  // Two guard bits cover the growth of the working parts during conversion.
  localparam int SW          = IN_WIDTH + 2;
  localparam int IN_TDATA_W  = ((2 * IN_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((MAX_DIGITS + CNT_W + 1 + 7) / 8) * 8;

  typedef struct packed {
    logic clear;  // start a new conversion: drop digits, place token at cell 0
    logic shift;  // one digit produced: capture it and advance the token
  } cell_ctrl_t;

  typedef struct packed {
    logic                 digit;
    logic signed [SW-1:0] next_real;
    logic signed [SW-1:0] next_imag;
  } step_out_t;

endpackage

// ----- sv/g2b_step.sv -----
// One division step by (i-1): emit the parity digit and form the next quotient.
module g2b_step (
  input  logic signed [g2b_pkg::SW-1:0] real_i,
  input  logic signed [g2b_pkg::SW-1:0] imag_i,
  output g2b_pkg::step_out_t            step_o
);
  import g2b_pkg::*;

  logic signed [SW:0]   sum;
  logic signed [SW:0]   sum_even;
  logic signed [SW-1:0] half;
  logic signed [SW-1:0] nb;

  always_comb begin
    sum      = {real_i[SW-1], real_i} + {imag_i[SW-1], imag_i};
    sum_even = sum - {{SW{1'b0}}, sum[0]};
    // Exact halving of an even value.
    half     = sum_even[SW:1];
    nb       = -half;
    step_o.digit     = sum[0];
    step_o.next_imag = nb;
    step_o.next_real = nb + imag_i;
  end

endmodule

// ----- sv/g2b_cell.sv -----
// Digit cell: holds one digit and passes the write token to its neighbor.
module g2b_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  g2b_pkg::cell_ctrl_t ctrl_i,
  input  logic                token_init_i,
  input  logic                token_i,
  input  logic                digit_i,
  output logic                token_o,
  output logic                digit_o
);
  import g2b_pkg::*;

  logic token_q;
  logic digit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= 1'b0;
      digit_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      token_q <= token_init_i;
      digit_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      token_q <= token_i;
      if (token_q) begin
        digit_q <= digit_i;
      end
    end
  end

  assign token_o = token_q;
  assign digit_o = digit_q;

endmodule

// ----- sv/gaussian_to_base_i_minus_one_top.sv -----
// Top level: converts a Gaussian integer to its digit string in complex base (i-1).
//
//  channel  | dir | tdata fields (lowest bit up)                 | role
//  s_axis   | in  | real_part[15:0], imag_part[31:16]            | Gaussian integer
//  m_axis   | out | digit_bits[63:0], digit_count[70:64], ovf[71] | digit string
//
// One input transfer is converted at a time: a load step, then the shared step
// unit emits the digits in turn, and a closing step; then the result waits in
// DONE until taken. A 16-bit input needs at most about 36 digits, and the digit
// count is capped at MAX_DIGITS.
// Reset clears the controller and the digit cells; no clearing pass is needed.
// A stalled output holds the result and keeps the input side not ready.
module gaussian_to_base_i_minus_one_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [g2b_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // real_part, imag_part
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [g2b_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // digit_bits, digit_count, overflow
);
  import g2b_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic signed [SW-1:0] real_q;
  logic signed [SW-1:0] imag_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 ovf_q;

  logic [IN_WIDTH-1:0]  in_real;
  logic [IN_WIDTH-1:0]  in_imag;
  logic                 in_xfer;
  logic                 finished;
  step_out_t            step;
  cell_ctrl_t           cell_ctrl;
  logic [MAX_DIGITS-1:0] token;
  logic [MAX_DIGITS-1:0] digits;
  logic [CNT_W-1:0]     count_out;

  assign in_real = s_axis_tdata[IN_WIDTH-1:0];
  assign in_imag = s_axis_tdata[2*IN_WIDTH-1:IN_WIDTH];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Stop when the quotient reaches zero or the digit budget is spent.
  assign finished = ((real_q == '0) && (imag_q == '0)) || (cnt_q == CNT_W'(MAX_DIGITS));

  g2b_step u_step (
    .real_i (real_q),
    .imag_i (imag_q),
    .step_o (step)
  );

  assign cell_ctrl.clear = in_xfer;
  assign cell_ctrl.shift = (state_q == ST_RUN) && !finished;

  // Row of digit cells; the token marks where the next digit lands.
  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
    logic token_prev;
    if (k == 0) begin : g_head
      assign token_prev = 1'b0;
    end else begin : g_body
      assign token_prev = token[k-1];
    end
    g2b_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .token_init_i ((k == 0) ? 1'b1 : 1'b0),
      .token_i      (token_prev),
      .digit_i      (step.digit),
      .token_o      (token[k]),
      .digit_o      (digits[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      real_q  <= '0;
      imag_q  <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            // Sign-extend the input parts into the working width.
            real_q  <= {{(SW-IN_WIDTH){in_real[IN_WIDTH-1]}}, in_real};
            imag_q  <= {{(SW-IN_WIDTH){in_imag[IN_WIDTH-1]}}, in_imag};
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (finished) begin
            ovf_q   <= (real_q != '0) || (imag_q != '0);
            state_q <= ST_DONE;
          end else begin
            real_q <= step.next_real;
            imag_q <= step.next_imag;
            cnt_q  <= cnt_q + CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Zero converts to the single digit 0.
  assign count_out     = (cnt_q == '0) ? CNT_W'(1) : cnt_q;
  assign m_axis_tvalid = (state_q == ST_DONE);
  assign m_axis_tdata  = OUT_TDATA_W'({ovf_q, count_out, digits});

  // The digit counter never runs past the budget.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_DIGITS))
    else $error("digit count exceeds budget");

  // At most one cell holds the write token.
  a_token_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(token))
    else $error("more than one write token in the cell row");

  // An accepted input starts a conversion in the next cycle.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_RUN) && (cnt_q == '0))
    else $error("conversion did not start after input transfer");

  // Overflow is only reported with a full digit string.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ovf_q) |-> (cnt_q == CNT_W'(MAX_DIGITS)))
    else $error("overflow flagged with a short digit string");

endmodule
